// File: rtl/partial_ipv4_address_parser_defines.svh
// Assertion macros used by the checker file.
`ifndef PARTIAL_IPV4_ADDRESS_PARSER_DEFINES_SVH
`define PARTIAL_IPV4_ADDRESS_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while dis is high.
`define IPAP_ASSERT_IMP(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, disabled while dis is high.
`define IPAP_ASSERT_NXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// File: rtl/ipap_pkg.sv
`timescale 1ns / 1ps

package ipap_pkg;

    localparam int CHAR_W = 8;
    localparam int ADDR_W = 32;
    localparam int PORT_W = 16;

    typedef enum logic [2:0] {
        PH_START,
        PH_GROUP,
        PH_PORT_WS,
        PH_PORT_DIG,
        PH_PORT_DONE
    } t_phase;

    // Configuration register indexes
    localparam logic CFG_LOCAL_ADDRESS = 1'b0;
    localparam logic CFG_DEFAULT_PORT  = 1'b1;

    localparam logic [PORT_W-1:0] DEFAULT_PORT_RESET = 16'd26000;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;

    localparam logic [9:0] GROUP_MAX  = 10'd255;
    localparam logic [1:0] MAX_DIGITS = 2'd3;
    localparam logic [2:0] MAX_GROUPS = 3'd4;

    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] char_code;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0] local_address;
        logic [PORT_W-1:0] default_port;
    } t_cfg;

    typedef struct packed {
        logic              failed;
        logic [PORT_W-1:0] port;
        logic [ADDR_W-1:0] address;
    } t_result;

endpackage

// File: rtl/ipap_in_reg.sv
`timescale 1ns / 1ps

module ipap_in_reg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [ipap_pkg::CHAR_W-1:0] i_data,
    output logic                      o_ready,
    input  logic                      i_consume,
    output ipap_pkg::t_in_item        o_item
);

    logic                        r_valid;
    logic                        n_valid;
    logic [ipap_pkg::CHAR_W-1:0] r_char;
    logic [ipap_pkg::CHAR_W-1:0] n_char;

    // Take a new item when empty or when the held one leaves this cycle.
    assign o_ready = i_rst_n && (!r_valid || i_consume);

    always_comb begin
        n_valid = r_valid;
        n_char  = r_char;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
            n_char  = i_data;
        end else if (i_consume) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_char <= n_char;
    end

    assign o_item.valid     = r_valid;
    assign o_item.char_code = r_char;

endmodule

// File: rtl/ipap_cfg.sv
`timescale 1ns / 1ps

module ipap_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_index,
    input  logic [ipap_pkg::ADDR_W-1:0] i_cfg_data,
    output logic                        o_cfg_ready,
    output ipap_pkg::t_cfg              o_cfg
);

    logic [ipap_pkg::ADDR_W-1:0] r_local_address;
    logic [ipap_pkg::ADDR_W-1:0] n_local_address;
    logic [ipap_pkg::PORT_W-1:0] r_default_port;
    logic [ipap_pkg::PORT_W-1:0] n_default_port;

    assign o_cfg_ready = i_rst_n;

    always_comb begin
        n_local_address = r_local_address;
        n_default_port  = r_default_port;
        if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ipap_pkg::CFG_LOCAL_ADDRESS: n_local_address = i_cfg_data;
                ipap_pkg::CFG_DEFAULT_PORT:  n_default_port  =
                    i_cfg_data[ipap_pkg::PORT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_address <= '0;
            r_default_port  <= ipap_pkg::DEFAULT_PORT_RESET;
        end else begin
            r_local_address <= n_local_address;
            r_default_port  <= n_default_port;
        end
    end

    assign o_cfg.local_address = r_local_address;
    assign o_cfg.default_port  = r_default_port;

endmodule

// File: rtl/ipap_parse.sv
`timescale 1ns / 1ps

module ipap_parse #(
    parameter int MAX_CHARS = 254
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ipap_pkg::t_in_item i_item,
    input  ipap_pkg::t_cfg     i_cfg,
    output logic               o_consume,
    input  logic               i_res_ready,
    output logic               o_res_valid,
    output ipap_pkg::t_result  o_res
);

    localparam int CW = $clog2(MAX_CHARS + 1);

    ipap_pkg::t_phase              r_phase, n_phase;
    logic [9:0]                    r_group_value, n_group_value;
    logic [1:0]                    r_digit_run, n_digit_run;
    logic [2:0]                    r_group_count, n_group_count;
    logic [ipap_pkg::ADDR_W-1:0]   r_partial, n_partial;
    logic [ipap_pkg::PORT_W-1:0]   r_port_value, n_port_value;
    logic                          r_port_neg, n_port_neg;
    logic [CW-1:0]                 r_char_count, n_char_count;
    logic                          r_error, n_error;
    logic                          r_res_valid, n_res_valid;
    ipap_pkg::t_result             r_res, n_res;

    logic                          term;
    logic                          in_group;
    logic                          gv_ok;
    logic                          is_digit;
    logic                          is_space;
    logic [ipap_pkg::CHAR_W-1:0]   c;
    logic [ipap_pkg::CHAR_W-1:0]   c_off;
    logic [9:0]                    gv_next;
    logic [ipap_pkg::PORT_W-1:0]   pv_next;
    logic [ipap_pkg::ADDR_W-1:0]   fin_partial;
    logic [2:0]                    fin_count;
    logic [2:0]                    cnt;
    logic [ipap_pkg::ADDR_W-1:0]   part;
    logic [ipap_pkg::ADDR_W-1:0]   mask;
    logic                          fail;

    // A terminator waits for a free result register; other characters never stall.
    assign term      = i_item.char_code == ipap_pkg::CH_NUL;
    assign o_consume = i_item.valid && (!term || !r_res_valid || i_res_ready);

    always_comb begin
        c        = i_item.char_code;
        c_off    = c - ipap_pkg::CH_ZERO;
        is_digit = (c >= ipap_pkg::CH_ZERO) && (c <= ipap_pkg::CH_NINE);
        is_space = (c == ipap_pkg::CH_SPACE) ||
                   ((c >= ipap_pkg::CH_TAB) && (c <= ipap_pkg::CH_CR));
        in_group = (r_phase == ipap_pkg::PH_START) || (r_phase == ipap_pkg::PH_GROUP);
        gv_ok    = r_group_value <= ipap_pkg::GROUP_MAX;
        gv_next  = {r_group_value[6:0], 3'b000} + {r_group_value[8:0], 1'b0} +
                   {6'd0, c_off[3:0]};
        pv_next  = {r_port_value[12:0], 3'b000} + {r_port_value[14:0], 1'b0} +
                   {12'd0, c_off[3:0]};
        fin_partial = {r_partial[23:0], r_group_value[7:0]};
        fin_count   = (r_group_count == ipap_pkg::MAX_GROUPS) ? r_group_count
                                                              : r_group_count + 3'd1;
        cnt  = in_group ? fin_count : r_group_count;
        part = in_group ? fin_partial : r_partial;
        mask = (cnt >= ipap_pkg::MAX_GROUPS) ? '0 : ('1 << {cnt[1:0], 3'b000});
        fail = r_error || (in_group && !gv_ok);

        n_phase       = r_phase;
        n_group_value = r_group_value;
        n_digit_run   = r_digit_run;
        n_group_count = r_group_count;
        n_partial     = r_partial;
        n_port_value  = r_port_value;
        n_port_neg    = r_port_neg;
        n_char_count  = r_char_count;
        n_error       = r_error;
        n_res_valid   = r_res_valid && !i_res_ready;
        n_res         = r_res;

        if (o_consume) begin
            if (term) begin
                n_res_valid     = 1'b1;
                n_res.failed    = fail;
                n_res.address   = fail ? '0 : ((i_cfg.local_address & mask) | part);
                n_res.port      = fail ? '0 :
                                  in_group ? i_cfg.default_port :
                                  r_port_neg ? ipap_pkg::PORT_W'(0 - r_port_value)
                                             : r_port_value;
                n_phase       = ipap_pkg::PH_START;
                n_group_value = '0;
                n_digit_run   = '0;
                n_group_count = '0;
                n_partial     = '0;
                n_port_value  = '0;
                n_port_neg    = 1'b0;
                n_char_count  = '0;
                n_error       = 1'b0;
            end else if (r_char_count < CW'(MAX_CHARS)) begin
                n_char_count = r_char_count + CW'(1);
                if (!r_error) begin
                    case (r_phase)
                        ipap_pkg::PH_START, ipap_pkg::PH_GROUP: begin
                            n_phase = ipap_pkg::PH_GROUP;
                            // drop a leading dot
                            if (!(r_phase == ipap_pkg::PH_START && c == ipap_pkg::CH_DOT))
                            begin
                                if (is_digit) begin
                                    if (r_digit_run == ipap_pkg::MAX_DIGITS) begin
                                        n_error = 1'b1;
                                    end else begin
                                        n_digit_run   = r_digit_run + 2'd1;
                                        n_group_value = gv_next;
                                    end
                                end else if (c == ipap_pkg::CH_DOT ||
                                             c == ipap_pkg::CH_COLON) begin
                                    if (!gv_ok) begin
                                        n_error = 1'b1;
                                    end else begin
                                        n_partial     = fin_partial;
                                        n_group_count = fin_count;
                                        n_group_value = '0;
                                        n_digit_run   = '0;
                                    end
                                    if (c == ipap_pkg::CH_COLON) begin
                                        n_phase = ipap_pkg::PH_PORT_WS;
                                    end
                                end else begin
                                    n_error = 1'b1;
                                end
                            end
                        end
                        ipap_pkg::PH_PORT_WS: begin
                            if (is_space) begin
                                n_phase = r_phase;
                            end else if (c == ipap_pkg::CH_PLUS ||
                                         c == ipap_pkg::CH_MINUS) begin
                                n_port_neg = c == ipap_pkg::CH_MINUS;
                                n_phase    = ipap_pkg::PH_PORT_DIG;
                            end else if (is_digit) begin
                                n_port_value = pv_next;
                                n_phase      = ipap_pkg::PH_PORT_DIG;
                            end else begin
                                n_phase = ipap_pkg::PH_PORT_DONE;
                            end
                        end
                        ipap_pkg::PH_PORT_DIG: begin
                            if (is_digit) begin
                                n_port_value = pv_next;
                            end else begin
                                n_phase = ipap_pkg::PH_PORT_DONE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= ipap_pkg::PH_START;
            r_group_value <= '0;
            r_digit_run   <= '0;
            r_group_count <= '0;
            r_partial     <= '0;
            r_port_value  <= '0;
            r_port_neg    <= 1'b0;
            r_char_count  <= '0;
            r_error       <= 1'b0;
            r_res_valid   <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_group_value <= n_group_value;
            r_digit_run   <= n_digit_run;
            r_group_count <= n_group_count;
            r_partial     <= n_partial;
            r_port_value  <= n_port_value;
            r_port_neg    <= n_port_neg;
            r_char_count  <= n_char_count;
            r_error       <= n_error;
            r_res_valid   <= n_res_valid;
        end
        r_res <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

// File: rtl/partial_ipv4_address_parser.sv
`timescale 1ns / 1ps
// A terminating character passes through the input register and then the result register.
// Throughput: one character per cycle, set by the combinational parse step between
// the input register and the result register; a held result stalls only a terminator.
// Reset: synchronous, active low; clears the parse state and both valid flags,
// local_address to 0 and default_port to 26000. Ready outputs stay low during reset.

module partial_ipv4_address_parser #(
    parameter int MAX_CHARS = 254
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input characters
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] char_code
    // parse results
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // [31:0] address, [47:32] port
    output logic        o_m_axis_tuser,   // [0] failed
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,      // 0 local_address, 1 default_port
    input  logic [31:0] i_cfg_data
);

    ipap_pkg::t_in_item in_item;
    ipap_pkg::t_cfg     cfg;
    ipap_pkg::t_result  res;
    logic               consume;

    // Input register: hold one character ahead of the parse step.
    ipap_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .i_data    (i_s_axis_tdata),
        .o_ready   (o_s_axis_tready),
        .i_consume (consume),
        .o_item    (in_item)
    );

    // Configuration registers; write them only while the parser is idle.
    ipap_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    // Parse step and result register: advance the groups and the port per
    // character, and assemble the address on the terminating zero.
    ipap_parse #(
        .MAX_CHARS (MAX_CHARS)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (in_item),
        .i_cfg       (cfg),
        .o_consume   (consume),
        .i_res_ready (i_m_axis_tready),
        .o_res_valid (o_m_axis_tvalid),
        .o_res       (res)
    );

    assign o_m_axis_tdata = {res.port, res.address};
    assign o_m_axis_tuser = res.failed;

endmodule

// File: rtl/ipap_checker.sv
`timescale 1ns / 1ps
`include "partial_ipv4_address_parser_defines.svh"

module ipap_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser
);

    logic        res_wait;
    logic        res_free;
    logic        res_fail;
    logic        res_zero;
    logic [48:0] res_word;

    assign res_wait = o_m_axis_tvalid && !i_m_axis_tready;
    assign res_free = !o_m_axis_tvalid || i_m_axis_tready;
    assign res_fail = o_m_axis_tvalid && o_m_axis_tuser;
    assign res_zero = o_m_axis_tdata == 48'd0;
    assign res_word = {o_m_axis_tuser, o_m_axis_tdata};

    // A stalled result holds.
    `IPAP_ASSERT_NXT(a_res_hold, i_clk, !i_rst_n, res_wait, o_m_axis_tvalid && $stable(res_word))

    // A failed parse reports zero address and port.
    `IPAP_ASSERT_IMP(a_fail_zero, i_clk, !i_rst_n, res_fail, res_zero)

    // With the result side free, characters are never refused.
    `IPAP_ASSERT_IMP(a_no_stall, i_clk, !i_rst_n, res_free, o_s_axis_tready)

    // Reset empties the result register.
    `IPAP_ASSERT_NXT(a_rst_empty, i_clk, 1'b0, !i_rst_n, !o_m_axis_tvalid)

endmodule

bind partial_ipv4_address_parser ipap_checker u_ipap_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
